@@ src/psched_pkg.sv @@
// Shared types and constants for the priority task scheduler.
`default_nettype none
package psched_pkg;
   localparam int NumTasks   = 16;
   localparam int SlotBits   = 4;
   localparam int LinkBits   = 5;
   localparam int Levels     = 32;
   localparam int LevelBits  = 5;
   localparam int TickBits   = 32;
   localparam logic [LinkBits-1:0] LINK_NIL = 5'd16;

   typedef enum logic [2:0] {
      OP_MAKE_READY = 3'd0,
      OP_SCHEDULE   = 3'd1,
      OP_DELAY      = 3'd2,
      OP_TICK       = 3'd3,
      OP_BLOCK      = 3'd4,
      OP_UNBLOCK    = 3'd5,
      OP_CHANGE     = 3'd6,
      OP_TERMINATE  = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      TS_FREE       = 3'd0,
      TS_READY      = 3'd1,
      TS_RUNNING    = 3'd2,
      TS_DELAYED    = 3'd3,
      TS_BLOCKED    = 3'd4,
      TS_TERMINATED = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EXEC,
      ST_APPEND,
      ST_SELECT,
      ST_WALK,
      ST_TICK,
      ST_LEAVE,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

@@ src/priority_task_scheduler.sv @@
// Top level of the priority task scheduler.
//
// Commands arrive as beats on the req_ channel (valid/stall); each command
// yields exactly one response beat on the rsp_ channel (valid/stall).
// The idle slot register is written through the csr_ channel (valid/ready).
// Write it only while no command is in flight; the block does not enforce it.
// An accepted command runs an execute step and then, as its operation needs,
// the queue append, queue or sleeper unlink and schedule select steps; a
// delay that lands behind the list head walks past each sleeper that wakes
// no later and then inserts, and a tick wakes each due sleeper in turn (up
// to 16). The response register loads in the final step.
// The sequencer holds one command at a time and takes the next one the cycle
// after the response loads, so no command starts before the last one's loads.
// A stalled response holds its payload; the sequencer then waits in its
// final step until the response register frees up.
// Reset clears all queues, the ready mask and the sleeper list, marks every
// slot free and runs slot 0.
`default_nettype none
module priority_task_scheduler (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [2:0]                        req_operation,
   input  wire logic [psched_pkg::SlotBits-1:0]   req_task_slot,
   input  wire logic [psched_pkg::LevelBits-1:0]  req_task_level,
   input  wire logic [psched_pkg::TickBits-1:0]   req_tick_value,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic      [psched_pkg::SlotBits-1:0]   rsp_running_task,
   output logic                                   rsp_preempt,
   output logic      [4:0]                        rsp_woken_count,
   output logic                                   rsp_accepted,
   output logic      [psched_pkg::Levels-1:0]     rsp_ready_mask,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [psched_pkg::SlotBits-1:0]   csr_idle_task_slot
);
   import psched_pkg::*;

   state_type state_ff, state_in;

   logic [LevelBits-1:0] prio_ff   [NumTasks];
   status_type           status_ff [NumTasks];
   logic [LinkBits-1:0]  next_ff   [NumTasks];
   logic [LinkBits-1:0]  prev_ff   [NumTasks];
   logic [TickBits-1:0]  wake_ff   [NumTasks];
   logic [LinkBits-1:0]  head_ff   [Levels];
   logic [LinkBits-1:0]  tail_ff   [Levels];
   logic [Levels-1:0]    mask_ff;
   logic [SlotBits-1:0]  running_ff;
   logic [LinkBits-1:0]  sleep_head_ff;
   logic [SlotBits-1:0]  idle_ff;

   op_type               op_ff;
   logic [SlotBits-1:0]  slot_ff;
   logic [LevelBits-1:0] lvl_ff;
   logic [TickBits-1:0]  tv_ff;
   logic [SlotBits-1:0]  tgt_ff;
   logic [LevelBits-1:0] apl_ff;
   logic [LinkBits-1:0]  cur_ff;
   logic [4:0]           guard_ff;
   logic [4:0]           woke_ff;
   logic                 higher_ff;
   logic                 acc_ff;
   logic                 sched_ff;
   logic                 still_ff;
   logic                 chg_ff;
   status_type           newst_ff;
   logic [LevelBits-1:0] rp_ff;

   logic                 rsp_valid_ff;
   logic [SlotBits-1:0]  rsp_running_ff;
   logic                 rsp_higher_ff;
   logic [4:0]           rsp_woken_ff;
   logic                 rsp_acc_ff;
   logic [Levels-1:0]    rsp_mask_ff;

   logic                 req_take;
   logic                 rsp_free;
   status_type           st_s, st_r;
   logic                 mr_ok, still, dly_ok, dly_front, blk_ok, unb_ok, chg_rdy, trm_ok;
   logic [LinkBits-1:0]  walk_nx;
   logic                 walk_adv, tick_wake;
   logic [LevelBits-1:0] top_level;

   psched_penc u_penc (
      .mask  (mask_ff),
      .level (top_level)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid & ~req_stall;
   assign rsp_free  = ~rsp_valid_ff | ~rsp_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_running_task = rsp_running_ff;
   assign rsp_preempt      = rsp_higher_ff;
   assign rsp_woken_count  = rsp_woken_ff;
   assign rsp_accepted     = rsp_acc_ff;
   assign rsp_ready_mask   = rsp_mask_ff;

   always_comb begin
      st_s      = status_ff[slot_ff];
      st_r      = status_ff[running_ff];
      mr_ok     = (st_s == TS_FREE) || (st_s == TS_TERMINATED);
      still     = (st_r == TS_RUNNING);
      dly_ok    = (running_ff != idle_ff) && still;
      dly_front = sleep_head_ff[SlotBits] ||
                  (tv_ff < wake_ff[sleep_head_ff[SlotBits-1:0]]);
      blk_ok    = (running_ff != idle_ff) &&
                  ((st_r == TS_RUNNING) || (st_r == TS_READY) || (st_r == TS_DELAYED));
      unb_ok    = (st_s == TS_BLOCKED);
      chg_rdy   = (st_s == TS_READY);
      trm_ok    = (slot_ff != idle_ff) && (st_s != TS_FREE) && (st_s != TS_TERMINATED);
      walk_nx   = next_ff[cur_ff[SlotBits-1:0]];
      walk_adv  = ~walk_nx[SlotBits] && (wake_ff[walk_nx[SlotBits-1:0]] <= tv_ff) &&
                  (guard_ff < 5'(NumTasks));
      tick_wake = (woke_ff < 5'(NumTasks)) && ~sleep_head_ff[SlotBits] &&
                  (wake_ff[sleep_head_ff[SlotBits-1:0]] <= tv_ff);
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            case (op_ff)
               OP_MAKE_READY: state_in = mr_ok ? ST_APPEND : ST_DONE;
               OP_SCHEDULE:   state_in = still ? ST_APPEND : ST_SELECT;
               OP_DELAY:      state_in = (dly_ok && !dly_front) ? ST_WALK : ST_DONE;
               OP_TICK:       state_in = ST_TICK;
               OP_BLOCK:      state_in = blk_ok ? ST_LEAVE : ST_DONE;
               OP_UNBLOCK:    state_in = unb_ok ? ST_APPEND : ST_DONE;
               OP_CHANGE:     state_in = chg_rdy ? ST_LEAVE : ST_DONE;
               OP_TERMINATE:  state_in = trm_ok ? ST_LEAVE : ST_DONE;
               default:       state_in = ST_DONE;
            endcase
         end
         ST_APPEND: state_in = sched_ff ? ST_SELECT : ST_DONE;
         ST_SELECT: state_in = ST_DONE;
         ST_WALK:   state_in = walk_adv ? ST_WALK : ST_DONE;
         ST_TICK:   state_in = tick_wake ? ST_TICK : ST_DONE;
         ST_LEAVE:  state_in = chg_ff ? ST_APPEND : ST_DONE;
         ST_DONE: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin : datapath
      logic [LinkBits-1:0]  n, v, t, nh, h;
      logic [LevelBits-1:0] p;
      logic [SlotBits-1:0]  w;
      if (reset) begin
         for (int i = 0; i < NumTasks; i++) begin
            prio_ff[i]   <= '0;
            status_ff[i] <= TS_FREE;
         end
         for (int i = 0; i < Levels; i++) begin
            head_ff[i] <= LINK_NIL;
            tail_ff[i] <= LINK_NIL;
         end
         mask_ff       <= '0;
         running_ff    <= '0;
         sleep_head_ff <= LINK_NIL;
         idle_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) idle_ff <= csr_idle_task_slot;
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_DONE)) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  op_ff     <= op_type'(req_operation);
                  slot_ff   <= req_task_slot;
                  lvl_ff    <= req_task_level;
                  tv_ff     <= req_tick_value;
                  acc_ff    <= 1'b0;
                  woke_ff   <= '0;
                  higher_ff <= 1'b0;
                  sched_ff  <= 1'b0;
                  chg_ff    <= 1'b0;
               end
            end
            ST_EXEC: begin
               case (op_ff)
                  OP_MAKE_READY: begin
                     if (mr_ok) begin
                        prio_ff[slot_ff] <= lvl_ff;
                        tgt_ff <= slot_ff;
                        apl_ff <= lvl_ff;
                        acc_ff <= 1'b1;
                     end
                  end
                  OP_SCHEDULE: begin
                     sched_ff <= 1'b1;
                     still_ff <= still;
                     tgt_ff   <= running_ff;
                     apl_ff   <= prio_ff[running_ff];
                     acc_ff   <= 1'b1;
                  end
                  OP_DELAY: begin
                     if (dly_ok) begin
                        acc_ff <= 1'b1;
                        wake_ff[running_ff]   <= tv_ff;
                        status_ff[running_ff] <= TS_DELAYED;
                        prev_ff[running_ff]   <= LINK_NIL;
                        tgt_ff <= running_ff;
                        if (dly_front) begin
                           next_ff[running_ff] <= sleep_head_ff[SlotBits] ? LINK_NIL
                                                                           : sleep_head_ff;
                           if (!sleep_head_ff[SlotBits])
                              prev_ff[sleep_head_ff[SlotBits-1:0]] <= {1'b0, running_ff};
                           sleep_head_ff <= {1'b0, running_ff};
                        end else begin
                           cur_ff   <= sleep_head_ff;
                           guard_ff <= '0;
                        end
                     end
                  end
                  OP_TICK: begin
                     rp_ff  <= prio_ff[running_ff];
                     acc_ff <= 1'b1;
                  end
                  OP_BLOCK: begin
                     if (blk_ok) begin
                        acc_ff   <= 1'b1;
                        tgt_ff   <= running_ff;
                        newst_ff <= TS_BLOCKED;
                     end
                  end
                  OP_UNBLOCK: begin
                     if (unb_ok) begin
                        acc_ff <= 1'b1;
                        tgt_ff <= slot_ff;
                        apl_ff <= prio_ff[slot_ff];
                     end
                  end
                  OP_CHANGE: begin
                     acc_ff <= 1'b1;
                     if (chg_rdy) begin
                        tgt_ff <= slot_ff;
                        apl_ff <= lvl_ff;
                        chg_ff <= 1'b1;
                     end else begin
                        prio_ff[slot_ff] <= lvl_ff;
                     end
                  end
                  OP_TERMINATE: begin
                     if (trm_ok) begin
                        acc_ff   <= 1'b1;
                        tgt_ff   <= slot_ff;
                        newst_ff <= TS_TERMINATED;
                     end
                  end
                  default: begin
                     acc_ff <= 1'b0;
                  end
               endcase
            end
            ST_APPEND: begin
               t = tail_ff[apl_ff];
               next_ff[tgt_ff] <= LINK_NIL;
               prev_ff[tgt_ff] <= t;
               if (!head_ff[apl_ff][SlotBits] && !t[SlotBits]) begin
                  next_ff[t[SlotBits-1:0]] <= {1'b0, tgt_ff};
               end else begin
                  head_ff[apl_ff] <= {1'b0, tgt_ff};
                  mask_ff[apl_ff] <= 1'b1;
               end
               tail_ff[apl_ff]   <= {1'b0, tgt_ff};
               status_ff[tgt_ff] <= TS_READY;
            end
            ST_SELECT: begin
               if (mask_ff != '0) begin
                  p = top_level;
                  t = head_ff[p];
                  if (!t[SlotBits]) begin
                     n = next_ff[t[SlotBits-1:0]];
                     if (!n[SlotBits]) begin
                        head_ff[p] <= n;
                        prev_ff[n[SlotBits-1:0]] <= LINK_NIL;
                     end else begin
                        head_ff[p] <= LINK_NIL;
                        tail_ff[p] <= LINK_NIL;
                        mask_ff[p] <= 1'b0;
                     end
                     next_ff[t[SlotBits-1:0]]   <= LINK_NIL;
                     prev_ff[t[SlotBits-1:0]]   <= LINK_NIL;
                     running_ff                 <= t[SlotBits-1:0];
                     status_ff[t[SlotBits-1:0]] <= TS_RUNNING;
                  end else begin
                     status_ff[running_ff] <= TS_RUNNING;
                  end
               end else if (!still_ff) begin
                  running_ff <= idle_ff;
                  if (status_ff[idle_ff] == TS_DELAYED) begin
                     n = next_ff[idle_ff];
                     v = prev_ff[idle_ff];
                     if (!v[SlotBits]) next_ff[v[SlotBits-1:0]] <= n;
                     else sleep_head_ff <= n[SlotBits] ? LINK_NIL : n;
                     if (!n[SlotBits]) prev_ff[n[SlotBits-1:0]] <= v;
                     next_ff[idle_ff] <= LINK_NIL;
                     prev_ff[idle_ff] <= LINK_NIL;
                  end
                  status_ff[idle_ff] <= TS_RUNNING;
               end else begin
                  status_ff[running_ff] <= TS_RUNNING;
               end
            end
            ST_WALK: begin
               if (walk_adv) begin
                  cur_ff   <= walk_nx;
                  guard_ff <= guard_ff + 5'd1;
               end else begin
                  next_ff[tgt_ff] <= walk_nx;
                  prev_ff[tgt_ff] <= cur_ff;
                  if (!walk_nx[SlotBits]) prev_ff[walk_nx[SlotBits-1:0]] <= {1'b0, tgt_ff};
                  next_ff[cur_ff[SlotBits-1:0]] <= {1'b0, tgt_ff};
               end
            end
            ST_TICK: begin
               if (tick_wake) begin
                  w = sleep_head_ff[SlotBits-1:0];
                  n = next_ff[w];
                  v = prev_ff[w];
                  if (!v[SlotBits]) next_ff[v[SlotBits-1:0]] <= n;
                  else sleep_head_ff <= n[SlotBits] ? LINK_NIL : n;
                  if (!n[SlotBits]) prev_ff[n[SlotBits-1:0]] <= v;
                  wake_ff[w] <= '0;
                  p = prio_ff[w];
                  t = tail_ff[p];
                  next_ff[w] <= LINK_NIL;
                  prev_ff[w] <= t;
                  if (!head_ff[p][SlotBits] && !t[SlotBits]) begin
                     next_ff[t[SlotBits-1:0]] <= {1'b0, w};
                  end else begin
                     head_ff[p] <= {1'b0, w};
                     mask_ff[p] <= 1'b1;
                  end
                  tail_ff[p]   <= {1'b0, w};
                  status_ff[w] <= TS_READY;
                  woke_ff      <= woke_ff + 5'd1;
                  if (p > rp_ff) higher_ff <= 1'b1;
               end
            end
            ST_LEAVE: begin
               n = next_ff[tgt_ff];
               v = prev_ff[tgt_ff];
               if (status_ff[tgt_ff] == TS_READY) begin
                  p = prio_ff[tgt_ff];
                  h = head_ff[p];
                  nh = v[SlotBits] ? n : h;
                  if (!v[SlotBits]) next_ff[v[SlotBits-1:0]] <= n;
                  if (!n[SlotBits]) prev_ff[n[SlotBits-1:0]] <= v;
                  if (nh[SlotBits]) begin
                     head_ff[p] <= LINK_NIL;
                     tail_ff[p] <= LINK_NIL;
                     mask_ff[p] <= 1'b0;
                  end else begin
                     if (v[SlotBits]) head_ff[p] <= n;
                     if (n[SlotBits]) tail_ff[p] <= v;
                  end
                  next_ff[tgt_ff] <= LINK_NIL;
                  prev_ff[tgt_ff] <= LINK_NIL;
               end else if (status_ff[tgt_ff] == TS_DELAYED) begin
                  if (!v[SlotBits]) next_ff[v[SlotBits-1:0]] <= n;
                  else sleep_head_ff <= n[SlotBits] ? LINK_NIL : n;
                  if (!n[SlotBits]) prev_ff[n[SlotBits-1:0]] <= v;
                  next_ff[tgt_ff] <= LINK_NIL;
                  prev_ff[tgt_ff] <= LINK_NIL;
               end
               if (chg_ff) prio_ff[tgt_ff] <= lvl_ff;
               else status_ff[tgt_ff] <= newst_ff;
            end
            ST_DONE: begin
               if (rsp_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_running_ff <= running_ff;
                  rsp_higher_ff  <= higher_ff;
                  rsp_woken_ff   <= woke_ff;
                  rsp_acc_ff     <= acc_ff;
                  rsp_mask_ff    <= mask_ff;
               end
            end
            default: begin
               acc_ff <= acc_ff;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

@@ src/psched_penc.sv @@
// Highest set bit finder over the ready mask.
`default_nettype none
module psched_penc (
   input  wire logic [psched_pkg::Levels-1:0]    mask,
   output logic      [psched_pkg::LevelBits-1:0] level
);
   import psched_pkg::*;

   always_comb begin
      level = '0;
      for (int i = 0; i < Levels; i++) begin
         if (mask[i]) begin
            level = LevelBits'(i);
         end
      end
   end
endmodule
`default_nettype wire

@@ tb/sv/psched_checker.sv @@
// Scoreboard for the priority task scheduler: predicts each response and compares it.
module psched_checker (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   input  wire logic                             req_stall,
   input  wire logic [2:0]                       req_operation,
   input  wire logic [psched_pkg::SlotBits-1:0]  req_task_slot,
   input  wire logic [psched_pkg::LevelBits-1:0] req_task_level,
   input  wire logic [psched_pkg::TickBits-1:0]  req_tick_value,
   input  wire logic                             rsp_valid,
   input  wire logic                             rsp_stall,
   input  wire logic [psched_pkg::SlotBits-1:0]  rsp_running_task,
   input  wire logic                             rsp_preempt,
   input  wire logic [4:0]                       rsp_woken_count,
   input  wire logic                             rsp_accepted,
   input  wire logic [psched_pkg::Levels-1:0]    rsp_ready_mask,
   input  wire logic                             csr_valid,
   input  wire logic                             csr_ready,
   input  wire logic [psched_pkg::SlotBits-1:0]  csr_idle_task_slot,
   output int                                    errors,
   output int                                    pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import psched_pkg::*;

   typedef struct packed {
      logic [3:0]  running;
      logic        higher;
      logic [4:0]  woken;
      logic        acc;
      logic [31:0] mask;
   } sched_rsp_type;

   logic [4:0]     prio [NumTasks];
   status_type     stat [NumTasks];
   int             nxt  [NumTasks];
   int             prv  [NumTasks];
   logic [31:0]    wake [NumTasks];
   int             qhead [Levels];
   int             qtail [Levels];
   logic [31:0]    mask;
   int             running;
   int             shead;
   int             idle;
   sched_rsp_type  expected_rsp [$];

   localparam int NIL = NumTasks;

   function automatic bit in_tab(int s);
      return s < NumTasks;
   endfunction

   task automatic sched_clear();
      for (int i = 0; i < NumTasks; i++) begin
         prio[i] = '0; stat[i] = TS_FREE; nxt[i] = NIL; prv[i] = NIL; wake[i] = '0;
      end
      for (int i = 0; i < Levels; i++) begin
         qhead[i] = NIL; qtail[i] = NIL;
      end
      mask = '0; running = 0; shead = NIL; idle = 0;
   endtask

   task automatic q_append(int s);
      int p, t;
      p = int'(prio[s]);
      t = qtail[p];
      nxt[s] = NIL;
      prv[s] = t;
      if (in_tab(qhead[p]) && in_tab(t)) begin
         nxt[t] = s;
      end else begin
         qhead[p] = s;
         mask[p] = 1'b1;
      end
      qtail[p] = s;
      stat[s] = TS_READY;
   endtask

   task automatic q_pop(int p, output int t);
      int n;
      t = qhead[p];
      if (in_tab(t)) begin
         n = nxt[t];
         qhead[p] = n;
         if (in_tab(n)) begin
            prv[n] = NIL;
         end else begin
            qhead[p] = NIL; qtail[p] = NIL; mask[p] = 1'b0;
         end
         nxt[t] = NIL;
         prv[t] = NIL;
      end
   endtask

   task automatic q_remove(int s);
      int p, n, v;
      p = int'(prio[s]); n = nxt[s]; v = prv[s];
      if (in_tab(v)) nxt[v] = n; else qhead[p] = n;
      if (in_tab(n)) prv[n] = v; else qtail[p] = v;
      if (!in_tab(qhead[p])) begin
         qhead[p] = NIL; qtail[p] = NIL; mask[p] = 1'b0;
      end
      nxt[s] = NIL;
      prv[s] = NIL;
   endtask

   task automatic sleeper_insert(int s);
      int cur, guard;
      cur = shead;
      guard = 0;
      stat[s] = TS_DELAYED;
      prv[s] = NIL;
      if (!in_tab(cur) || wake[s] < wake[cur]) begin
         nxt[s] = in_tab(cur) ? cur : NIL;
         if (in_tab(cur)) prv[cur] = s;
         shead = s;
      end else begin
         while (guard < NumTasks && in_tab(nxt[cur]) && wake[nxt[cur]] <= wake[s]) begin
            guard++;
            cur = nxt[cur];
         end
         nxt[s] = nxt[cur];
         prv[s] = cur;
         if (in_tab(nxt[cur])) prv[nxt[cur]] = s;
         nxt[cur] = s;
      end
   endtask

   task automatic sleeper_remove(int s);
      int n, v;
      n = nxt[s]; v = prv[s];
      if (in_tab(v)) nxt[v] = n; else shead = in_tab(n) ? n : NIL;
      if (in_tab(n)) prv[n] = v;
      nxt[s] = NIL;
      prv[s] = NIL;
   endtask

   task automatic leave_lists(int s);
      if (stat[s] == TS_READY) q_remove(s);
      else if (stat[s] == TS_DELAYED) sleeper_remove(s);
   endtask

   task automatic run_command(logic [2:0] op, int s, int lvl, logic [31:0] tv,
                              output sched_rsp_type e);
      bit acc, higher, still;
      int woke, r, p, rp, w;
      acc = 0; higher = 0; woke = 0; r = running;
      case (op_type'(op))
         OP_MAKE_READY: begin
            if (stat[s] == TS_FREE || stat[s] == TS_TERMINATED) begin
               prio[s] = lvl[4:0];
               q_append(s);
               acc = 1;
            end
         end
         OP_SCHEDULE: begin
            still = stat[r] == TS_RUNNING;
            if (still) q_append(r);
            if (mask != 0) begin
               p = Levels - 1;
               while (p > 0 && !mask[p]) p--;
               q_pop(p, w);
               if (in_tab(w)) running = w;
            end else if (!still) begin
               running = idle;
               if (stat[running] == TS_DELAYED) sleeper_remove(running);
            end
            stat[running] = TS_RUNNING;
            acc = 1;
         end
         OP_DELAY: begin
            if (r != idle && stat[r] == TS_RUNNING) begin
               wake[r] = tv;
               sleeper_insert(r);
               acc = 1;
            end
         end
         OP_TICK: begin
            rp = int'(prio[r]);
            while (woke < NumTasks && in_tab(shead) && wake[shead] <= tv) begin
               w = shead;
               sleeper_remove(w);
               wake[w] = '0;
               q_append(w);
               woke++;
               if (int'(prio[w]) > rp) higher = 1;
            end
            acc = 1;
         end
         OP_BLOCK: begin
            if (r != idle && (stat[r] == TS_RUNNING || stat[r] == TS_READY ||
                              stat[r] == TS_DELAYED)) begin
               leave_lists(r);
               stat[r] = TS_BLOCKED;
               acc = 1;
            end
         end
         OP_UNBLOCK: begin
            if (stat[s] == TS_BLOCKED) begin
               q_append(s);
               acc = 1;
            end
         end
         OP_CHANGE: begin
            if (stat[s] == TS_READY) begin
               q_remove(s);
               prio[s] = lvl[4:0];
               q_append(s);
            end else begin
               prio[s] = lvl[4:0];
            end
            acc = 1;
         end
         default: begin
            if (s != idle && stat[s] != TS_FREE && stat[s] != TS_TERMINATED) begin
               leave_lists(s);
               stat[s] = TS_TERMINATED;
               acc = 1;
            end
         end
      endcase
      e.running = running[3:0];
      e.higher  = higher;
      e.woken   = woke[4:0];
      e.acc     = acc;
      e.mask    = mask;
   endtask

   always @(posedge clock) begin
      sched_rsp_type e, got;
      if (reset) begin
         sched_clear();
         expected_rsp.delete();
         errors  = 0;
         pending = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_running_task, rsp_preempt, rsp_woken_count,
                    rsp_accepted, rsp_ready_mask};
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response beat %p", $time, got);
            end else begin
               e = expected_rsp.pop_front();
               if (got.running != e.running) begin
                  errors++;
                  $display("%0t: running_task expected %0d actual %0d",
                           $time, e.running, got.running);
               end
               if (got.higher != e.higher) begin
                  errors++;
                  $display("%0t: preempt expected %0d actual %0d",
                           $time, e.higher, got.higher);
               end
               if (got.woken != e.woken) begin
                  errors++;
                  $display("%0t: woken_count expected %0d actual %0d",
                           $time, e.woken, got.woken);
               end
               if (got.acc != e.acc) begin
                  errors++;
                  $display("%0t: accepted expected %0d actual %0d", $time, e.acc, got.acc);
               end
               if (got.mask != e.mask) begin
                  errors++;
                  $display("%0t: ready_mask expected %h actual %h", $time, e.mask, got.mask);
               end
            end
         end
         if (req_valid && !req_stall) begin
            run_command(req_operation, int'(req_task_slot), int'(req_task_level),
                        req_tick_value, e);
            expected_rsp.push_back(e);
         end
         if (csr_valid && csr_ready) idle = int'(csr_idle_task_slot);
         pending = expected_rsp.size();
      end
   end
endmodule

@@ tb/sv/tb.sv @@
// Stimulus top for the priority task scheduler: drives commands and gives the verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import psched_pkg::*;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [2:0]           req_operation = '0;
   logic [SlotBits-1:0]  req_task_slot = '0;
   logic [LevelBits-1:0] req_task_level = '0;
   logic [TickBits-1:0]  req_tick_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [SlotBits-1:0]  rsp_running_task;
   logic                 rsp_preempt;
   logic [4:0]           rsp_woken_count;
   logic                 rsp_accepted;
   logic [Levels-1:0]    rsp_ready_mask;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [SlotBits-1:0]  csr_idle_task_slot = '0;
   int                   errors;
   int                   pending;
   int                   burst_left = 0;
   int                   stall_cycle = 0;
   int                   sent = 0;
   logic [31:0]          now = '0;

   always #1 clock = ~clock;

   priority_task_scheduler u_top (.*);

   psched_checker u_chk (.*);

   always @(negedge clock) begin
      stall_cycle <= stall_cycle + 1;
      case ((stall_cycle / 97) % 3)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 30);
         default: rsp_stall <= ($urandom_range(0, 99) < 75);
      endcase
   end

   task automatic send_cmd(op_type op, int s, int lvl, logic [31:0] tv);
      int gap;
      @(negedge clock);
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_task_slot  <= s[3:0];
      req_task_level <= lvl[4:0];
      req_tick_value <= tv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_idle(logic [3:0] v);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_idle_task_slot <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_cmd();
      int k;
      logic [31:0] tv;
      k = $urandom_range(0, 99);
      if (k < 15) send_cmd(OP_MAKE_READY, $urandom_range(0, 15), $urandom_range(0, 31),
                           $urandom);
      else if (k < 38) send_cmd(OP_SCHEDULE, $urandom_range(0, 15), $urandom_range(0, 31),
                                $urandom);
      else if (k < 52) begin
         tv = ($urandom_range(0, 9) == 0) ? $urandom : now + $urandom_range(0, 12);
         send_cmd(OP_DELAY, $urandom_range(0, 15), $urandom_range(0, 31), tv);
      end else if (k < 68) begin
         if ($urandom_range(0, 19) == 0) tv = $urandom;
         else begin
            now = now + $urandom_range(0, 6);
            tv = now;
         end
         send_cmd(OP_TICK, $urandom_range(0, 15), $urandom_range(0, 31), tv);
      end else if (k < 75) send_cmd(OP_BLOCK, $urandom_range(0, 15), $urandom_range(0, 31),
                                    $urandom);
      else if (k < 83) send_cmd(OP_UNBLOCK, $urandom_range(0, 15), $urandom_range(0, 31),
                                $urandom);
      else if (k < 91) send_cmd(OP_CHANGE, $urandom_range(0, 15), $urandom_range(0, 31),
                                $urandom);
      else send_cmd(OP_TERMINATE, $urandom_range(0, 15), $urandom_range(0, 31), $urandom);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      write_idle(4'd0);

      send_cmd(OP_SCHEDULE,   0, 0, 32'h0);
      send_cmd(OP_MAKE_READY, 1, 31, 32'hFFFF_FFFF);
      send_cmd(OP_MAKE_READY, 2, 0, 32'h0);
      send_cmd(OP_MAKE_READY, 1, 5, 32'h0);
      send_cmd(OP_DELAY,      0, 0, 32'h5);
      send_cmd(OP_BLOCK,      0, 0, 32'h0);
      send_cmd(OP_SCHEDULE,   0, 0, 32'h0);
      send_cmd(OP_DELAY,      0, 0, 32'h5);
      send_cmd(OP_SCHEDULE,   0, 0, 32'h0);
      send_cmd(OP_DELAY,      0, 0, 32'h5);
      send_cmd(OP_SCHEDULE,   0, 0, 32'h0);
      send_cmd(OP_TICK,       0, 0, 32'h4);
      send_cmd(OP_TICK,       0, 0, 32'h5);
      send_cmd(OP_CHANGE,     2, 31, 32'h0);
      send_cmd(OP_CHANGE,     15, 17, 32'h0);
      send_cmd(OP_SCHEDULE,   0, 0, 32'h0);
      send_cmd(OP_BLOCK,      0, 0, 32'h0);
      send_cmd(OP_UNBLOCK,    2, 0, 32'h0);
      send_cmd(OP_UNBLOCK,    3, 0, 32'h0);
      send_cmd(OP_TERMINATE,  0, 0, 32'h0);
      send_cmd(OP_TERMINATE,  1, 0, 32'h0);
      send_cmd(OP_TERMINATE,  9, 0, 32'h0);
      send_cmd(OP_MAKE_READY, 1, 7, 32'h0);
      send_cmd(OP_TICK,       0, 0, 32'hFFFF_FFFF);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: write_idle(4'd15);
            1: write_idle(4'($urandom_range(1, 14)));
            2: write_idle(4'd0);
            default: write_idle(4'($urandom_range(0, 15)));
         endcase
         repeat (95) random_cmd();
      end

      drain();
      $display("Ran %0d commands over four idle-slot settings with bursty requests", sent);
      $display("and a varying response stall pattern; %0d field errors.", errors);
      if (errors == 0) begin
         $display("priority_task_scheduler: match");
      end else begin
         $display("priority_task_scheduler: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("priority_task_scheduler: mismatch");
      $finish;
   end
endmodule
